// ----- sv/scpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpq_pkg
// Shared types, constants and index helpers for the sorted circular
// priority queue.
// ----------------------------------------------------------------------------
package scpq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 20;
  localparam int TAG_W = 16;
  localparam int CAP_W = 5;
  localparam int STATUS_W = 2;
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-1:0] CAP_ADDR = '0;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]    out_tag;
    logic [STATUS_W-1:0] status;
    logic [CAP_W-1:0]    fill_level;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHECK,
    S_INS_CMP,
    S_REM_OUT,
    S_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic                load_item;
    logic                wr_first;
    logic                ins_start;
    logic                rd_prev;
    logic                rd_head;
    logic                wr_new;
    logic                wr_shift;
    logic                res_clr;
    logic [STATUS_W-1:0] res_code;
    logic                rem_take;
    logic                out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind;
    logic full;
    logic empty;
    logic at_head;
    logic new_lt_rd;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic             wr;
    logic [CAP_W-1:0] value;
  } cfg_wr_t;

  // capacity 0 behaves as 1, anything above DEPTH saturates
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] r;
    if (cap == '0) begin
      r = CNT_W'(1);
    end else if (CNT_W'(cap) > CNT_W'(DEPTH)) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(cap);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(i) + CNT_W'(1);
    return (n >= cap) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] p;
    p = cap - CNT_W'(1);
    return (i == '0) ? IDX_W'(p) : i - IDX_W'(1);
  endfunction

endpackage

// ----- sv/scpq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpq_ctrl
// Sequencer for queue operations: dispatches an insert or remove, walks the
// insertion point toward the head, then hands the result to the output.
// ----------------------------------------------------------------------------
module scpq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scpq_pkg::dp_status_t sts,
  output scpq_pkg::dp_cmd_t    cmd
);

  scpq_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != scpq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      scpq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = scpq_pkg::S_DISPATCH;
        end
      end
      scpq_pkg::S_DISPATCH: begin
        cmd.res_clr = 1'b1;
        if (sts.kind == scpq_pkg::KIND_INSERT) begin
          if (sts.full) begin
            cmd.res_code = scpq_pkg::STATUS_FULL;
            state_next   = scpq_pkg::S_DONE;
          end else if (sts.empty) begin
            cmd.res_code = scpq_pkg::STATUS_OK;
            cmd.wr_first = 1'b1;
            state_next   = scpq_pkg::S_DONE;
          end else begin
            cmd.res_code  = scpq_pkg::STATUS_OK;
            cmd.ins_start = 1'b1;
            state_next    = scpq_pkg::S_INS_CHECK;
          end
        end else begin
          if (sts.empty) begin
            cmd.res_code = scpq_pkg::STATUS_EMPTY;
            state_next   = scpq_pkg::S_DONE;
          end else begin
            cmd.res_code = scpq_pkg::STATUS_OK;
            cmd.rd_head  = 1'b1;
            state_next   = scpq_pkg::S_REM_OUT;
          end
        end
      end
      scpq_pkg::S_INS_CHECK: begin
        if (sts.at_head) begin
          cmd.wr_new = 1'b1;
          state_next = scpq_pkg::S_DONE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = scpq_pkg::S_INS_CMP;
        end
      end
      scpq_pkg::S_INS_CMP: begin
        if (sts.new_lt_rd) begin
          cmd.wr_shift = 1'b1;
          state_next   = scpq_pkg::S_INS_CHECK;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = scpq_pkg::S_DONE;
        end
      end
      scpq_pkg::S_REM_OUT: begin
        cmd.rem_take = 1'b1;
        state_next   = scpq_pkg::S_DONE;
      end
      scpq_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = scpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = scpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/scpq_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpq_dp
// Queue storage, head/tail pointers, fill count, capacity register and the
// output register.
// ----------------------------------------------------------------------------
module scpq_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  scpq_pkg::in_item_t   in_data,
  input  scpq_pkg::cfg_wr_t    cfg,
  output logic [scpq_pkg::CAP_W-1:0] capacity,
  input  scpq_pkg::dp_cmd_t    cmd,
  output scpq_pkg::dp_status_t sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scpq_pkg::out_item_t  out_data
);

  logic [scpq_pkg::KEY_W-1:0] key_mem [scpq_pkg::DEPTH];
  logic [scpq_pkg::TAG_W-1:0] tag_mem [scpq_pkg::DEPTH];

  logic [scpq_pkg::IDX_W-1:0] head_ptr;
  logic [scpq_pkg::IDX_W-1:0] tail_ptr;
  logic [scpq_pkg::IDX_W-1:0] cursor;
  logic [scpq_pkg::CNT_W-1:0] occupancy;
  logic [scpq_pkg::CNT_W-1:0] cap_eff;

  scpq_pkg::in_item_t item;
  logic [scpq_pkg::KEY_W-1:0] rd_key;
  logic [scpq_pkg::TAG_W-1:0] rd_tag;

  logic [scpq_pkg::KEY_W-1:0]    res_key;
  logic [scpq_pkg::TAG_W-1:0]    res_tag;
  logic [scpq_pkg::STATUS_W-1:0] res_status;

  logic                       mem_we;
  logic [scpq_pkg::IDX_W-1:0] mem_wa;
  logic [scpq_pkg::KEY_W-1:0] mem_wkey;
  logic [scpq_pkg::TAG_W-1:0] mem_wtag;
  logic [scpq_pkg::IDX_W-1:0] mem_ra;
  logic [scpq_pkg::IDX_W-1:0] cursor_prev;

  assign cap_eff     = scpq_pkg::eff_cap(capacity);
  assign cursor_prev = scpq_pkg::prev_idx(cursor, cap_eff);

  assign sts.kind      = item.kind;
  assign sts.full      = (occupancy >= cap_eff);
  assign sts.empty     = (occupancy == '0);
  assign sts.at_head   = (cursor == head_ptr);
  assign sts.new_lt_rd = (item.key < rd_key);
  assign sts.out_free  = !out_valid || !out_stall;

  // single write port: first entry, final placement, or one-step shift
  always_comb begin
    mem_we   = cmd.wr_first | cmd.wr_new | cmd.wr_shift;
    mem_wa   = cmd.wr_first ? '0 : cursor;
    mem_wkey = cmd.wr_shift ? rd_key : item.key;
    mem_wtag = cmd.wr_shift ? rd_tag : item.tag;
    mem_ra   = cmd.rd_head ? head_ptr : cursor_prev;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wkey;
      tag_mem[mem_wa] <= mem_wtag;
    end
    if (cmd.rd_head || cmd.rd_prev) begin
      rd_key <= key_mem[mem_ra];
      rd_tag <= tag_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.res_clr) begin
      res_key    <= '0;
      res_tag    <= '0;
      res_status <= cmd.res_code;
    end else if (cmd.rem_take) begin
      res_key <= rd_key;
      res_tag <= rd_tag;
    end
    if (cmd.out_load) begin
      out_data.out_key    <= res_key;
      out_data.out_tag    <= res_tag;
      out_data.status     <= res_status;
      out_data.fill_level <= scpq_pkg::CAP_W'(occupancy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= scpq_pkg::CAP_RESET;
      head_ptr  <= '0;
      tail_ptr  <= '0;
      cursor    <= '0;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.wr) begin
        capacity  <= cfg.value;
        head_ptr  <= '0;
        tail_ptr  <= '0;
        occupancy <= '0;
      end
      if (cmd.wr_first) begin
        head_ptr  <= '0;
        tail_ptr  <= '0;
        occupancy <= scpq_pkg::CNT_W'(1);
      end
      if (cmd.ins_start) begin
        tail_ptr <= scpq_pkg::next_idx(tail_ptr, cap_eff);
        cursor   <= scpq_pkg::next_idx(tail_ptr, cap_eff);
      end
      if (cmd.wr_shift) begin
        cursor <= cursor_prev;
      end
      if (cmd.wr_new) begin
        occupancy <= occupancy + scpq_pkg::CNT_W'(1);
      end
      if (cmd.rem_take) begin
        occupancy <= occupancy - scpq_pkg::CNT_W'(1);
        if (occupancy == scpq_pkg::CNT_W'(1)) begin
          head_ptr <= '0;
          tail_ptr <= '0;
        end else begin
          head_ptr <= scpq_pkg::next_idx(head_ptr, cap_eff);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  function automatic logic CNT_W_head_ok(input logic [scpq_pkg::IDX_W-1:0] p,
                                         input logic [scpq_pkg::CNT_W-1:0] c);
    return scpq_pkg::CNT_W'(p) < c;
  endfunction

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= cap_eff)
    else $error("occupancy exceeds effective capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (CNT_W_head_ok(head_ptr, cap_eff) && CNT_W_head_ok(tail_ptr, cap_eff)))
    else $error("pointer outside active range");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (occupancy == '0) |-> (head_ptr == '0 && tail_ptr == '0))
    else $error("empty queue with nonzero pointers");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled transaction");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_shift |-> (item.key < rd_key))
    else $error("shift without strictly larger key");

endmodule

// ----- sv/sorted_circular_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_circular_priority_queue
// Bounded priority queue kept in ascending key order in a circular buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_stall/in_data): one operation per transaction,
//     kind 0 inserts {key, tag}, kind 1 removes the lowest-key entry. Equal
//     keys leave in arrival order.
//   out channel (out_valid/out_stall/out_data): exactly one result per
//     operation: removed key/tag (zero otherwise), status and fill level.
//   APB port: register 0 at address 0 is the capacity (1..16 in use, 0 acts
//     as 1, larger values as 16). Writing it empties the queue. Write only
//     while no operation is in flight.
// Sequencing: operations run one at a time. Rejected inserts, inserts into
//   an empty queue and removes from an empty queue go from dispatch straight
//   to the result step; a remove first does one registered memory read of the
//   head. Any other insert walks the insertion point toward the head past each
//   stored entry with a larger key, one entry per read/compare pair on the
//   storage with its single write port.
// Reset empties the queue and sets capacity to 16. A stalled result stays
//   in the output register; the next operation is accepted meanwhile and
//   waits in its final step until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_circular_priority_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  scpq_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output scpq_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scpq_pkg::APB_AW-1:0]       paddr,
  input  logic [scpq_pkg::APB_DW-1:0]       pwdata,
  output logic [scpq_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  scpq_pkg::dp_cmd_t    cmd;
  scpq_pkg::dp_status_t sts;
  scpq_pkg::cfg_wr_t    cfg;
  logic [scpq_pkg::CAP_W-1:0] capacity;

  assign pready    = 1'b1;
  assign cfg.wr    = psel && penable && pwrite && (paddr == scpq_pkg::CAP_ADDR);
  assign cfg.value = pwdata[scpq_pkg::CAP_W-1:0];
  assign prdata    = (paddr == scpq_pkg::CAP_ADDR) ?
                     scpq_pkg::APB_DW'(capacity) : '0;

  scpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scpq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg       (cfg),
    .capacity  (capacity),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- test/tb_sorted_circular_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_circular_priority_queue
// Self-checking bench for the sorted circular priority queue. A short table of
// directed operations covers the edges of each field, ties and the full and
// empty cases, and switches capacity to 2, 0 and 31. After that, random phases
// drive fill/drain runs at several capacities and under several idle and
// stall patterns. One phase also holds off the output long enough to back up
// the input. Every result is checked in order against a queue model kept in
// the bench.
// ----------------------------------------------------------------------------
module tb_sorted_circular_priority_queue;

  localparam int RST_CYCLES   = 12;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 8;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int N_VEC        = 26;
  localparam int N_PHASE      = 8;

  typedef struct packed {
    logic                          cfg;     // capacity write instead of an operation
    logic [scpq_pkg::CAP_W-1:0]    cap;
    logic                          kind;
    logic [scpq_pkg::KEY_W-1:0]    key;
    logic [scpq_pkg::TAG_W-1:0]    tag;
    logic                          typed;   // expected result given below
    logic [scpq_pkg::KEY_W-1:0]    w_key;
    logic [scpq_pkg::TAG_W-1:0]    w_tag;
    logic [scpq_pkg::STATUS_W-1:0] w_status;
    logic [scpq_pkg::CAP_W-1:0]    w_fill;
  } vec_row_t;

  localparam vec_row_t DIR_VEC [N_VEC] = '{
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_EMPTY, 5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'hFFFFF, 16'hFFFF,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd1},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h00000, 16'h0000,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd2},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h80000, 16'h5555,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h80000, 16'hAAAA,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h7FFFF, 16'h0001,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd4},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'hFFFFF, 16'hFFFF,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b1, 20'hFFFFF, 16'hFFFF, scpq_pkg::STATUS_OK, 5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_EMPTY, 5'd0},
    '{1'b1, 5'd2,  scpq_pkg::KIND_INSERT, 20'h00000, 16'h0000,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h00123, 16'hBEEF,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h00100, 16'h1111,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h00050, 16'h2222,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_FULL,  5'd2},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_EMPTY, 5'd0},
    // capacity 0 acts as a single slot
    '{1'b1, 5'd0,  scpq_pkg::KIND_INSERT, 20'h00000, 16'h0000,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h0A5A5, 16'h5A5A,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd1},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h0F0F0, 16'h0F0F,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_FULL,  5'd1},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b1, 20'h0A5A5, 16'h5A5A, scpq_pkg::STATUS_OK, 5'd0},
    // capacity above the array size saturates
    '{1'b1, 5'd31, scpq_pkg::KIND_INSERT, 20'h00000, 16'h0000,
      1'b0, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd0},
    '{1'b0, 5'd0,  scpq_pkg::KIND_INSERT, 20'h12345, 16'h6789,
      1'b1, 20'h0, 16'h0, scpq_pkg::STATUS_OK,    5'd1},
    '{1'b0, 5'd0,  scpq_pkg::KIND_REMOVE, 20'h00000, 16'h0000,
      1'b1, 20'h12345, 16'h6789, scpq_pkg::STATUS_OK, 5'd0}
  };

  localparam logic [scpq_pkg::CAP_W-1:0] PH_CAP [N_PHASE] =
    '{5'd16, 5'd1, 5'd5, 5'd16, 5'd3, 5'd20, 5'd0, 5'd16};
  localparam int PH_GAP   [N_PHASE] = '{0, 83, 0, 8, 8, 8, 0, 0};
  localparam int PH_STALL [N_PHASE] = '{0, 0, 83, 8, 8, 8, 0, 0};
  localparam int PH_OPS   [N_PHASE] = '{140, 60, 100, 120, 70, 60, 30, 40};
  localparam bit PH_HOLD  [N_PHASE] = '{0, 0, 0, 0, 0, 0, 0, 1};

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  scpq_pkg::in_item_t          in_data;
  logic                        out_valid;
  logic                        out_stall;
  scpq_pkg::out_item_t         out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [scpq_pkg::APB_AW-1:0] paddr;
  logic [scpq_pkg::APB_DW-1:0] pwdata;
  logic [scpq_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  // queue model
  logic [scpq_pkg::KEY_W-1:0] pq_key [scpq_pkg::DEPTH];
  logic [scpq_pkg::TAG_W-1:0] pq_tag [scpq_pkg::DEPTH];
  int                         pq_head  = 0;
  int                         pq_tail  = 0;
  int                         pq_count = 0;
  logic [scpq_pkg::CAP_W-1:0] pq_cap   = scpq_pkg::CAP_RESET;

  scpq_pkg::out_item_t results_due[$];
  scpq_pkg::out_item_t due;

  int gap_pct   = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int cycles    = 0;
  int errors    = 0;
  int n_checked = 0;
  int n_ops     = 0;
  int n_removed = 0;
  int n_full    = 0;
  int n_empty   = 0;
  int n_cfg     = 0;

  sorted_circular_priority_queue DUT (
    .clk, .rst,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_slots();
    if (pq_cap == '0) return 1;
    if (int'(pq_cap) > scpq_pkg::DEPTH) return scpq_pkg::DEPTH;
    return int'(pq_cap);
  endfunction

  // applies one operation to the model and returns its result
  function automatic scpq_pkg::out_item_t queue_step(input scpq_pkg::in_item_t op);
    scpq_pkg::out_item_t        r;
    int                         lim;
    int                         i;
    int                         j;
    logic [scpq_pkg::KEY_W-1:0] tk;
    logic [scpq_pkg::TAG_W-1:0] tt;
    lim = active_slots();
    r = '0;
    r.status = scpq_pkg::STATUS_OK;
    pq_head = pq_head % lim;
    pq_tail = pq_tail % lim;
    if (op.kind == scpq_pkg::KIND_INSERT) begin
      if (pq_count >= lim) begin
        r.status = scpq_pkg::STATUS_FULL;
      end else if (pq_count == 0) begin
        pq_head = 0;
        pq_tail = 0;
        pq_key[0] = op.key;
        pq_tag[0] = op.tag;
        pq_count = 1;
      end else begin
        pq_tail = (pq_tail + 1 >= lim) ? 0 : pq_tail + 1;
        pq_key[pq_tail] = op.key;
        pq_tag[pq_tail] = op.tag;
        i = pq_tail;
        j = (i == 0) ? lim - 1 : i - 1;
        // strict compare keeps equal keys in arrival order
        while (i != pq_head && pq_key[i] < pq_key[j]) begin
          tk = pq_key[i];
          tt = pq_tag[i];
          pq_key[i] = pq_key[j];
          pq_tag[i] = pq_tag[j];
          pq_key[j] = tk;
          pq_tag[j] = tt;
          i = j;
          j = (i == 0) ? lim - 1 : i - 1;
        end
        pq_count++;
      end
    end else if (pq_count == 0) begin
      r.status = scpq_pkg::STATUS_EMPTY;
    end else begin
      r.out_key = pq_key[pq_head];
      r.out_tag = pq_tag[pq_head];
      pq_count--;
      if (pq_count == 0) begin
        pq_head = 0;
        pq_tail = 0;
      end else begin
        pq_head = (pq_head + 1 >= lim) ? 0 : pq_head + 1;
      end
    end
    r.fill_level = scpq_pkg::CAP_W'(pq_count);
    return r;
  endfunction

  task automatic send_op(input scpq_pkg::in_item_t op, input bit typed,
                         input scpq_pkg::out_item_t want);
    scpq_pkg::out_item_t pred;
    @(negedge clk);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = queue_step(op);
    results_due.push_back(typed ? want : pred);
    n_ops++;
    case (pred.status)
      scpq_pkg::STATUS_FULL:  n_full++;
      scpq_pkg::STATUS_EMPTY: n_empty++;
      default:                if (op.kind == scpq_pkg::KIND_REMOVE) n_removed++;
    endcase
  endtask

  // capacity write, only once the queue has gone quiet
  task automatic write_capacity(input logic [scpq_pkg::CAP_W-1:0] value);
    logic [scpq_pkg::APB_DW-1:0] word;
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    word = $urandom();
    word[scpq_pkg::CAP_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= scpq_pkg::CAP_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pq_cap   = value;
    pq_head  = 0;
    pq_tail  = 0;
    pq_count = 0;
    n_cfg++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // output side: random stall, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result key=%h tag=%h status=%0d fill=%0d",
                   out_data.out_key, out_data.out_tag, out_data.status,
                   out_data.fill_level);
      end else begin
        due = results_due.pop_front();
        n_checked++;
        if (out_data.out_key !== due.out_key || out_data.out_tag !== due.out_tag ||
            out_data.status !== due.status || out_data.fill_level !== due.fill_level) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $write("mismatch #%0d: exp key=%h tag=%h status=%0d fill=%0d, ",
                   n_checked, due.out_key, due.out_tag, due.status, due.fill_level);
            $display("got key=%h tag=%h status=%0d fill=%0d",
                     out_data.out_key, out_data.out_tag, out_data.status,
                     out_data.fill_level);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               results_due.size());
      $display("** sorted_circular_priority_queue: FAILED **");
      $finish;
    end
  end

  initial begin
    scpq_pkg::in_item_t  op;
    scpq_pkg::out_item_t want;
    vec_row_t            row;
    int                  lim;
    bit                  filling;
    rst     <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    filling = 1'b1;
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    for (int v = 0; v < N_VEC; v++) begin
      row = DIR_VEC[v];
      if (row.cfg) begin
        write_capacity(row.cap);
      end else begin
        op.kind = row.kind;
        op.key  = row.key;
        op.tag  = row.tag;
        want.out_key    = row.w_key;
        want.out_tag    = row.w_tag;
        want.status     = row.w_status;
        want.fill_level = row.w_fill;
        send_op(op, row.typed, want);
      end
    end

    for (int p = 0; p < N_PHASE; p++) begin
      write_capacity(PH_CAP[p]);
      gap_pct   = PH_GAP[p];
      stall_pct = PH_STALL[p];
      if (PH_HOLD[p]) hold_req = 1'b1;
      for (int n = 0; n < PH_OPS[p]; n++) begin
        // alternate fill and drain runs so full and empty are both reached
        lim = active_slots();
        if (pq_count >= lim) filling = 1'b0;
        else if (pq_count == 0) filling = 1'b1;
        else if ($urandom_range(99) < 4) filling = !filling;
        op.kind = ($urandom_range(99) < (filling ? 80 : 20)) ?
                  scpq_pkg::KIND_INSERT : scpq_pkg::KIND_REMOVE;
        case ($urandom_range(9))
          0, 1, 2: op.key = scpq_pkg::KEY_W'($urandom_range(7));   // many ties
          3:       op.key = $urandom_range(1) ? '1 : '0;
          default: op.key = scpq_pkg::KEY_W'($urandom);
        endcase
        op.tag = scpq_pkg::TAG_W'($urandom);
        send_op(op, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $write("ran %0d operations over %0d capacity settings: ", n_ops, n_cfg);
    $display("%0d removals, %0d full drops, %0d empty removes",
             n_removed, n_full, n_empty);
    $display("checked %0d results, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("** sorted_circular_priority_queue: PASSED **");
    end else begin
      $display("** sorted_circular_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
